// ----- sv/syn_pt_pkg.sv -----
// ----------------------------------------------------------------------------
// syn_pt_pkg
// Shared types and codes of the SYN probe tracker.
// ----------------------------------------------------------------------------
package syn_pt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_FLIGHT = 3'd4;

    // command codes
    localparam logic [1:0] CMD_ISSUE = 2'd0;
    localparam logic [1:0] CMD_RESP  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_RESULT = 2'd1;
    localparam logic [1:0] KIND_BUSY   = 2'd2;

    // port states
    localparam logic [1:0] PST_OPEN     = 2'd0;
    localparam logic [1:0] PST_CLOSED   = 2'd1;
    localparam logic [1:0] PST_FILTERED = 2'd2;
    localparam logic [1:0] PST_UNKNOWN  = 2'd3;

    typedef struct packed {
        logic [15:0] port;
        logic [31:0] deadline;
        logic [3:0]  attempts;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port;
        logic [1:0]  port_state;
        logic [15:0] rtt_ticks;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    finish;
        t_result res;
    } t_stage_req;

    typedef struct packed {
        logic can_push;
        logic can_finish;
    } t_stage_sts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_ISSUE,
        ST_FIN
    } t_state;

endpackage

// ----- sv/syn_pt_in_if.sv -----
// ----------------------------------------------------------------------------
// syn_pt_in_if
// Command channel of the SYN probe tracker.
// ----------------------------------------------------------------------------
interface syn_pt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] probe_port;
    logic [31:0] resp_source_addr;
    logic [15:0] resp_dest_port;
    logic [15:0] resp_source_port;
    logic        resp_syn_ack;
    logic        resp_rst;

    modport source (
        output valid, cmd, probe_port, resp_source_addr, resp_dest_port,
               resp_source_port, resp_syn_ack, resp_rst,
        input  ready
    );
    modport sink (
        input  valid, cmd, probe_port, resp_source_addr, resp_dest_port,
               resp_source_port, resp_syn_ack, resp_rst,
        output ready
    );
endinterface

// ----- sv/syn_pt_out_if.sv -----
// ----------------------------------------------------------------------------
// syn_pt_out_if
// Result channel of the SYN probe tracker.
// ----------------------------------------------------------------------------
interface syn_pt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] port;
    logic [1:0]  port_state;
    logic [15:0] rtt_ticks;
    logic        last;

    modport source (
        output valid, kind, port, port_state, rtt_ticks, last,
        input  ready
    );
    modport sink (
        input  valid, kind, port, port_state, rtt_ticks, last,
        output ready
    );
endinterface

// ----- sv/syn_pt_mem.sv -----
// ----------------------------------------------------------------------------
// syn_pt_mem
// Probe table store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module syn_pt_mem #(
    parameter  int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output syn_pt_pkg::t_entry  o_rd_data,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  syn_pt_pkg::t_entry  i_wr_data
);

    syn_pt_pkg::t_entry r_mem [DEPTH];
    syn_pt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/syn_pt_out.sv -----
// ----------------------------------------------------------------------------
// syn_pt_out
// Result staging: one pending result plus the output register. A result
// leaves pending only once the next one, or the end of the command, is known,
// so that the last flag can be set on it.
// ----------------------------------------------------------------------------
module syn_pt_out (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  syn_pt_pkg::t_stage_req i_req,
    output syn_pt_pkg::t_stage_sts o_sts,
    syn_pt_out_if.source           o_out
);

    logic                r_pend_v;
    syn_pt_pkg::t_result r_pend;
    logic                r_out_v;
    syn_pt_pkg::t_result r_out;
    logic                r_out_last;
    logic                out_free;
    logic                move;

    assign out_free = !r_out_v || o_out.ready;
    assign move     = r_pend_v && (i_req.push || i_req.finish);

    assign o_sts.can_push   = !r_pend_v || out_free;
    assign o_sts.can_finish = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_req.push) begin
                r_pend_v <= 1'b1;
            end else if (i_req.finish) begin
                r_pend_v <= 1'b0;
            end
            if (move) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_pend <= i_req.res;
        end
        if (move) begin
            r_out      <= r_pend;
            r_out_last <= i_req.finish;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.kind       = r_out.kind;
    assign o_out.port       = r_out.port;
    assign o_out.port_state = r_out.port_state;
    assign o_out.rtt_ticks  = r_out.rtt_ticks;
    assign o_out.last       = r_out_last;

    a_push_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.push |-> o_sts.can_push)
        else $error("result pushed while staging full");

    a_push_xor_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.push && i_req.finish))
        else $error("push and finish together");

    a_finish_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.finish && r_pend_v && o_sts.can_finish) |=> (r_out_v && r_out_last))
        else $error("final result not flagged last");

endmodule

// ----- sv/syn_probe_tracker.sv -----
// ----------------------------------------------------------------------------
// syn_probe_tracker
// Tracks in-flight SYN probes in a table memory; a sequencer walks the table
// for every command and reports send requests, port results and rejects.
//
//  channel  | dir | transfer when      | payload
//  ---------+-----+--------------------+-------------------------------------
//  i_in     | in  | valid && ready     | cmd, probe, response header fields
//  o_out    | out | valid && ready     | kind, port, port_state, rtt, last
//  i_cfg_*  | in  | i_cfg_we           | register index, write data
//
// A command walks the table through its single read port, one entry per
// cycle while o_out does not stall; a response whose address, port or
// flags do not match skips the walk. A response ends its walk at the
// matching entry. Stalls on o_out hold the walk in place. Reset clears
// the valid flags at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module syn_probe_tracker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    syn_pt_in_if.sink                          i_in,
    syn_pt_out_if.source                       o_out,
    input  logic                               i_cfg_we,
    input  logic [syn_pt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [syn_pt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // configuration
    logic [15:0] r_local_port;
    logic [31:0] r_target_addr;
    logic [15:0] r_timeout;
    logic [3:0]  r_retry;
    logic [4:0]  r_max_if;

    // table state outside the memory
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_now;

    // command context
    syn_pt_pkg::t_state r_state, n_state;
    logic [1:0]   r_cmd;
    logic [15:0]  r_pport;
    logic [15:0]  r_sport;
    logic         r_synack;
    logic [31:0]  r_base;
    logic [IDX_W-1:0] r_cur;
    logic [CNT_W-1:0] r_used;
    logic         r_dup;
    logic         r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    // memory access
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_idx;
    syn_pt_pkg::t_entry mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_idx;
    syn_pt_pkg::t_entry mem_wr_data;

    syn_pt_pkg::t_stage_req req;
    syn_pt_pkg::t_stage_sts sts;

    logic             in_xfer;
    logic             resp_ok;
    logic             cur_v;
    logic [31:0]      age;
    logic [31:0]      rtt_full;
    logic [15:0]      rtt_sat;
    logic [CNT_W-1:0] limit;
    logic             busy;
    logic             adv;
    logic             clr_valid;
    logic             set_valid;

    syn_pt_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_idx  (mem_rd_idx),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_idx  (mem_wr_idx),
        .i_wr_data (mem_wr_data)
    );

    syn_pt_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_sts   (sts),
        .o_out   (o_out)
    );

    assign i_in.ready = (r_state == syn_pt_pkg::ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign resp_ok    = (i_in.resp_source_addr == r_target_addr)
                     && (i_in.resp_dest_port == r_local_port)
                     && (i_in.resp_syn_ack || i_in.resp_rst);

    assign cur_v    = r_valid[r_cur];
    assign age      = r_now - mem_rd_data.deadline;
    assign rtt_full = r_base - mem_rd_data.deadline;
    assign rtt_sat  = (|rtt_full[31:16]) ? 16'hFFFF : rtt_full[15:0];

    always_comb begin
        if (r_max_if == 5'd0) begin
            limit = CNT_W'(1);
        end else if (int'(r_max_if) > TABLE_ENTRIES) begin
            limit = CNT_W'(TABLE_ENTRIES);
        end else begin
            limit = CNT_W'(r_max_if);
        end
    end

    assign busy = (r_used >= limit) || (!r_dup && !r_free_found);

    // sequencer: next state and strobes
    always_comb begin
        n_state     = r_state;
        mem_rd_en   = 1'b0;
        mem_rd_idx  = r_cur + IDX_W'(1);
        mem_wr_en   = 1'b0;
        mem_wr_idx  = r_cur;
        mem_wr_data = '0;
        req         = '0;
        adv         = 1'b0;
        clr_valid   = 1'b0;
        set_valid   = 1'b0;

        case (r_state)
            syn_pt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in.cmd == syn_pt_pkg::CMD_RESP && !resp_ok) begin
                        n_state = syn_pt_pkg::ST_FIN;
                    end else begin
                        n_state = syn_pt_pkg::ST_START;
                    end
                end
            end

            syn_pt_pkg::ST_START: begin
                mem_rd_en  = 1'b1;
                mem_rd_idx = '0;
                n_state    = syn_pt_pkg::ST_SCAN;
            end

            syn_pt_pkg::ST_SCAN: begin
                case (r_cmd)
                    syn_pt_pkg::CMD_RESP: begin
                        if (cur_v && mem_rd_data.port == r_sport) begin
                            req.push           = 1'b1;
                            req.res.kind       = syn_pt_pkg::KIND_RESULT;
                            req.res.port       = r_sport;
                            req.res.port_state = r_synack ? syn_pt_pkg::PST_OPEN
                                                          : syn_pt_pkg::PST_CLOSED;
                            req.res.rtt_ticks  = rtt_sat;
                            clr_valid          = 1'b1;
                        end
                    end
                    syn_pt_pkg::CMD_TICK: begin
                        if (cur_v && !age[31]) begin
                            req.push     = 1'b1;
                            req.res.port = mem_rd_data.port;
                            if (mem_rd_data.attempts != 4'd0) begin
                                req.res.kind         = syn_pt_pkg::KIND_SEND;
                                mem_wr_en            = 1'b1;
                                mem_wr_data.port     = mem_rd_data.port;
                                mem_wr_data.deadline = r_base;
                                mem_wr_data.attempts = mem_rd_data.attempts - 4'd1;
                            end else begin
                                req.res.kind       = syn_pt_pkg::KIND_RESULT;
                                req.res.port_state = syn_pt_pkg::PST_FILTERED;
                                req.res.rtt_ticks  = r_timeout;
                                clr_valid          = 1'b1;
                            end
                        end
                    end
                    syn_pt_pkg::CMD_FLUSH: begin
                        if (cur_v) begin
                            req.push           = 1'b1;
                            req.res.kind       = syn_pt_pkg::KIND_RESULT;
                            req.res.port       = mem_rd_data.port;
                            req.res.port_state = syn_pt_pkg::PST_UNKNOWN;
                            clr_valid          = 1'b1;
                        end
                    end
                    default: begin
                        // issue: statistics only, gathered below
                    end
                endcase

                adv = !req.push || sts.can_push;
                if (!adv) begin
                    // hold the entry until the staging frees up
                    req.push  = 1'b0;
                    mem_wr_en = 1'b0;
                    clr_valid = 1'b0;
                end else if (r_cur == LAST_IDX || (r_cmd == syn_pt_pkg::CMD_RESP && req.push))
                begin
                    n_state = (r_cmd == syn_pt_pkg::CMD_ISSUE) ? syn_pt_pkg::ST_ISSUE
                                                               : syn_pt_pkg::ST_FIN;
                end else begin
                    mem_rd_en = 1'b1;
                end
            end

            syn_pt_pkg::ST_ISSUE: begin
                if (sts.can_push) begin
                    req.push     = 1'b1;
                    req.res.kind = busy ? syn_pt_pkg::KIND_BUSY : syn_pt_pkg::KIND_SEND;
                    req.res.port = r_pport;
                    if (!busy && !r_dup) begin
                        mem_wr_en            = 1'b1;
                        mem_wr_idx           = r_free_idx;
                        mem_wr_data.port     = r_pport;
                        mem_wr_data.deadline = r_base;
                        mem_wr_data.attempts = r_retry;
                        set_valid            = 1'b1;
                    end
                    n_state = syn_pt_pkg::ST_FIN;
                end
            end

            syn_pt_pkg::ST_FIN: begin
                if (sts.can_finish) begin
                    req.finish = 1'b1;
                    n_state    = syn_pt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = syn_pt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= syn_pt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_port  <= 16'd40000;
            r_target_addr <= 32'd0;
            r_timeout     <= 16'd1000;
            r_retry       <= 4'd1;
            r_max_if      <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                syn_pt_pkg::CFG_LOCAL_PORT:    r_local_port  <= i_cfg_data[15:0];
                syn_pt_pkg::CFG_TARGET_ADDR:   r_target_addr <= i_cfg_data[31:0];
                syn_pt_pkg::CFG_TIMEOUT_TICKS: r_timeout     <= i_cfg_data[15:0];
                syn_pt_pkg::CFG_RETRY_COUNT:   r_retry       <= i_cfg_data[3:0];
                syn_pt_pkg::CFG_MAX_IN_FLIGHT: r_max_if      <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // valid flags and time base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_now   <= 32'd0;
        end else begin
            if (in_xfer && i_in.cmd == syn_pt_pkg::CMD_TICK) begin
                r_now <= r_now + 32'd1;
            end
            if (clr_valid) begin
                r_valid[r_cur] <= 1'b0;
            end
            if (set_valid) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // command context and walk statistics
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd    <= i_in.cmd;
            r_pport  <= i_in.probe_port;
            r_sport  <= i_in.resp_source_port;
            r_synack <= i_in.resp_syn_ack;
        end
        if (r_state == syn_pt_pkg::ST_START) begin
            // r_now already holds the advanced time on a tick
            r_base       <= r_now + {16'd0, r_timeout};
            r_cur        <= '0;
            r_used       <= '0;
            r_dup        <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else if (r_state == syn_pt_pkg::ST_SCAN && adv) begin
            if (mem_rd_en) begin
                r_cur <= r_cur + IDX_W'(1);
            end
            if (cur_v) begin
                r_used <= r_used + CNT_W'(1);
                if (mem_rd_data.port == r_pport) begin
                    r_dup <= 1'b1;
                end
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cur;
            end
        end
    end

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_idx != mem_rd_idx))
        else $error("table read and write hit the same entry");

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.cmd == syn_pt_pkg::CMD_TICK) |=> (r_now == $past(r_now) + 32'd1))
        else $error("tick did not advance time");

    a_fill_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid |-> !r_valid[r_free_idx])
        else $error("issue overwrote a live entry");

    a_fin_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == syn_pt_pkg::ST_FIN) |-> (!mem_wr_en && !req.push))
        else $error("table activity after the walk ended");

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SYN probe tracker. A short table of directed
// commands covers the extremes and corner cases, then random phases with
// changing register settings drive well-formed probe traffic mixed with noise.
// Every result transfer is checked against an in-bench model of the table.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import syn_pt_pkg::*;

    localparam int SLOTS           = 16;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 2 * (SLOTS + 4);
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 64;
    localparam int PORT_POOL       = 12;

    // state field is zero on send requests and busy rejects
    localparam logic [1:0] PST_NONE = PST_OPEN;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] probe_port;
        logic [31:0] saddr;
        logic [15:0] dport;
        logic [15:0] sport;
        logic        syn_ack;
        logic        rst;
    } probe_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port;
        logic [1:0]  port_state;
        logic [15:0] rtt;
        logic        last;
    } probe_res_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        probe_cmd_t            cmd;
        bit                    has_res;
        probe_res_t            res;
    } dir_row_t;

    typedef enum int {RX_FREE, RX_COIN, RX_PATTERN} rx_mode_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    syn_pt_in_if  in_if ();
    syn_pt_out_if out_if ();

    syn_probe_tracker #(
        .TABLE_ENTRIES(SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5ns i_clk = ~i_clk;

    // model of the probe table and registers
    logic [15:0] cfg_local_port;
    logic [31:0] cfg_target;
    logic [15:0] cfg_timeout;
    logic [3:0]  cfg_retry;
    logic [4:0]  cfg_max_inflight;
    bit          slot_busy     [SLOTS];
    logic [15:0] slot_port     [SLOTS];
    logic [31:0] slot_deadline [SLOTS];
    logic [3:0]  slot_tries    [SLOTS];
    logic [31:0] tick_now;

    probe_res_t  step_q[$];
    probe_res_t  expected_q[$];
    logic [15:0] port_pool[PORT_POOL];

    bit run_started;
    bit pressure_req;
    int err_cnt;
    int items_in;
    int items_directed;
    int idle_cycles;
    int burst_left;
    int settings_used;
    int kind_cnt[3];

    function automatic void emit_result(logic [1:0] kind, logic [15:0] port,
                                        logic [1:0] st, logic [15:0] rtt);
        probe_res_t r;
        r = '{kind: kind, port: port, port_state: st, rtt: rtt, last: 1'b0};
        step_q = {step_q, r};
    endfunction

    // results of one command into step_q; table state updated
    function automatic int predict_probe(probe_cmd_t c);
        int          lim;
        int          used;
        int          free_slot;
        bit          dup;
        bit          hit;
        logic [31:0] age;
        step_q.delete();
        case (c.cmd)
            CMD_ISSUE: begin
                lim = int'(cfg_max_inflight);
                if (lim < 1) lim = 1;
                if (lim > SLOTS) lim = SLOTS;
                used = 0;
                free_slot = -1;
                dup = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i]) begin
                        used++;
                        if (slot_port[i] == c.probe_port) dup = 1'b1;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                // full table wins over the duplicate check
                if (used >= lim || (!dup && free_slot < 0)) begin
                    emit_result(KIND_BUSY, c.probe_port, PST_NONE, 16'd0);
                end else begin
                    if (!dup) begin
                        slot_busy[free_slot]     = 1'b1;
                        slot_port[free_slot]     = c.probe_port;
                        slot_deadline[free_slot] = tick_now + {16'd0, cfg_timeout};
                        slot_tries[free_slot]    = cfg_retry;
                    end
                    emit_result(KIND_SEND, c.probe_port, PST_NONE, 16'd0);
                end
            end
            CMD_RESP: begin
                hit = 1'b0;
                if (c.saddr == cfg_target && c.dport == cfg_local_port &&
                    (c.syn_ack || c.rst)) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!hit && slot_busy[i] && slot_port[i] == c.sport) begin
                            hit = 1'b1;
                            age = tick_now + {16'd0, cfg_timeout} - slot_deadline[i];
                            emit_result(KIND_RESULT, c.sport,
                                        c.syn_ack ? PST_OPEN : PST_CLOSED,
                                        (age > 32'hFFFF) ? 16'hFFFF : age[15:0]);
                            slot_busy[i] = 1'b0;
                        end
                    end
                end
            end
            CMD_TICK: begin
                tick_now = tick_now + 32'd1;
                for (int i = 0; i < SLOTS; i++) begin
                    age = tick_now - slot_deadline[i];
                    // half-range compare: deadline at or before now
                    if (slot_busy[i] && !age[31]) begin
                        if (slot_tries[i] != 4'd0) begin
                            slot_tries[i]    = slot_tries[i] - 4'd1;
                            slot_deadline[i] = tick_now + {16'd0, cfg_timeout};
                            emit_result(KIND_SEND, slot_port[i], PST_NONE, 16'd0);
                        end else begin
                            emit_result(KIND_RESULT, slot_port[i], PST_FILTERED,
                                        cfg_timeout);
                            slot_busy[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i]) begin
                        emit_result(KIND_RESULT, slot_port[i], PST_UNKNOWN, 16'd0);
                        slot_busy[i] = 1'b0;
                    end
                end
            end
        endcase
        if (step_q.size() != 0) step_q[step_q.size()-1].last = 1'b1;
        return step_q.size();
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r.is_cfg  = 1'b1;
        r.idx     = idx;
        r.data    = data;
        r.cmd     = '0;
        r.has_res = 1'b0;
        r.res     = '0;
        return r;
    endfunction

    function automatic dir_row_t cmd_row(logic [1:0] cmd, logic [15:0] pport,
                                         logic [31:0] saddr, logic [15:0] dport,
                                         logic [15:0] sport, logic sa, logic rs);
        dir_row_t r;
        r.is_cfg  = 1'b0;
        r.idx     = '0;
        r.data    = '0;
        r.cmd     = '{cmd: cmd, probe_port: pport, saddr: saddr, dport: dport,
                      sport: sport, syn_ack: sa, rst: rs};
        r.has_res = 1'b0;
        r.res     = '0;
        return r;
    endfunction

    function automatic dir_row_t with_result(dir_row_t r, logic [1:0] kind,
                                             logic [15:0] port, logic [1:0] st,
                                             logic [15:0] rtt);
        dir_row_t o;
        o = r;
        o.has_res = 1'b1;
        o.res = '{kind: kind, port: port, port_state: st, rtt: rtt, last: 1'b1};
        return o;
    endfunction

    function automatic probe_cmd_t random_probe();
        probe_cmd_t  c;
        int          pick;
        int          flags;
        logic [15:0] live[$];
        c.cmd        = 2'($urandom);
        c.probe_port = 16'($urandom);
        c.saddr      = $urandom;
        c.dport      = 16'($urandom);
        c.sport      = 16'($urandom);
        c.syn_ack    = 1'($urandom);
        c.rst        = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            c.cmd = CMD_ISSUE;
            if ($urandom_range(0, 9) != 0) c.probe_port = port_pool[$urandom_range(0, PORT_POOL-1)];
        end else if (pick < 72) begin
            c.cmd   = CMD_RESP;
            c.saddr = cfg_target;
            c.dport = cfg_local_port;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_busy[i]) live = {live, slot_port[i]};
            end
            if (live.size() != 0 && $urandom_range(0, 4) != 0)
                c.sport = live[$urandom_range(0, live.size()-1)];
            else
                c.sport = port_pool[$urandom_range(0, PORT_POOL-1)];
            flags = $urandom_range(0, 19);
            if (flags < 3) begin
                c.syn_ack = 1'b0;
                c.rst     = 1'b0;
            end else if (flags < 11) begin
                c.syn_ack = 1'b0;
                c.rst     = 1'b1;
            end else begin
                c.syn_ack = 1'b1;
            end
            // stray segment: wrong host or wrong local port
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) != 0)
                    c.saddr = cfg_target ^ ($urandom | 32'd1);
                else
                    c.dport = cfg_local_port ^ 16'($urandom_range(1, 65535));
            end
        end else if (pick < 96) begin
            c.cmd = CMD_TICK;
        end else begin
            c.cmd = CMD_FLUSH;
        end
        return c;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v,
                                        logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, exp_v, got_v);
            err_cnt++;
        end
    endfunction

    task automatic sender_gap(int n);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic offer(input probe_cmd_t c, input bit has_res,
                         input probe_res_t res, output int n_res);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(24, 48)
                                                    : $urandom_range(1, 12);
            sender_gap(($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(1, 5));
        end
        burst_left--;
        @(negedge i_clk);
        in_if.cmd              <= c.cmd;
        in_if.probe_port       <= c.probe_port;
        in_if.resp_source_addr <= c.saddr;
        in_if.resp_dest_port   <= c.dport;
        in_if.resp_source_port <= c.sport;
        in_if.resp_syn_ack     <= c.syn_ack;
        in_if.resp_rst         <= c.rst;
        in_if.valid            <= 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        n_res = predict_probe(c);
        if (has_res) begin
            expected_q = {expected_q, res};
        end else begin
            foreach (step_q[k]) expected_q = {expected_q, step_q[k]};
        end
        items_in++;
    endtask

    // block idle: every result in, then the walk of a command with no result
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_LOCAL_PORT:    cfg_local_port   = data[15:0];
            CFG_TARGET_ADDR:   cfg_target       = data[31:0];
            CFG_TIMEOUT_TICKS: cfg_timeout      = data[15:0];
            CFG_RETRY_COUNT:   cfg_retry        = data[3:0];
            CFG_MAX_IN_FLIGHT: cfg_max_inflight = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        probe_res_t want;
        if (run_started && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: kind %0d port %0h state %0d rtt %0h",
                         $time, out_if.kind, out_if.port, out_if.port_state,
                         out_if.rtt_ticks);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_if.kind));
                check_field("port", 32'(want.port), 32'(out_if.port));
                check_field("port_state", 32'(want.port_state), 32'(out_if.port_state));
                check_field("rtt_ticks", 32'(want.rtt), 32'(out_if.rtt_ticks));
                check_field("last", 32'(want.last), 32'(out_if.last));
                if (want.kind < 2'd3) kind_cnt[want.kind]++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (run_started) begin
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: %0d cycles without a transfer, %0d results pending",
                         $time, idle_cycles, expected_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result receiver: changing stall patterns, one long hold-off on request
    initial begin : rx_side
        rx_mode_t   mode;
        int         seg_left;
        int         hold;
        logic [7:0] pat;
        out_if.ready = 1'b0;
        mode = RX_FREE;
        seg_left = 0;
        hold = 0;
        pat = 8'hFF;
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                hold = PRESSURE_CYCLES;
                pressure_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = rx_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(16, 96);
                    pat      = 8'($urandom) | 8'h01;
                end
                seg_left--;
                case (mode)
                    RX_FREE:  out_if.ready <= 1'b1;
                    RX_COIN:  out_if.ready <= 1'($urandom);
                    default: begin
                        out_if.ready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        dir_row_t   rows[$];
        probe_cmd_t it;
        int         n;
        int         counted;
        logic [4:0] max_list[RANDOM_PHASES];

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        in_if.valid            = 1'b0;
        in_if.cmd              = CMD_TICK;
        in_if.probe_port       = '0;
        in_if.resp_source_addr = '0;
        in_if.resp_dest_port   = '0;
        in_if.resp_source_port = '0;
        in_if.resp_syn_ack     = 1'b0;
        in_if.resp_rst         = 1'b0;

        cfg_local_port   = 16'd40000;
        cfg_target       = 32'd0;
        cfg_timeout      = 16'd1000;
        cfg_retry        = 4'd1;
        cfg_max_inflight = 5'd16;
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i]     = 1'b0;
            slot_port[i]     = '0;
            slot_deadline[i] = '0;
            slot_tries[i]    = '0;
        end
        tick_now     = '0;
        run_started  = 1'b0;
        pressure_req = 1'b0;
        err_cnt      = 0;
        items_in     = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        settings_used = 0;
        kind_cnt     = '{0, 0, 0};
        max_list     = '{5'd16, 5'd31, 5'd1, 5'd16, 5'd0, 5'($urandom_range(2, 15))};

        // reset values, extremes of ports, duplicates, stray responses
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'h0000, '0, '0, '0, 0, 0),
                                  KIND_SEND, 16'h0000, PST_NONE, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'hFFFF, '1, '1, '1, 1, 1),
                                  KIND_SEND, 16'hFFFF, PST_NONE, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'h0000, '0, '0, '0, 0, 0),
                                  KIND_SEND, 16'h0000, PST_NONE, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_RESP, '1, 32'd0, 16'd40000, 16'h0000, 1, 1),
                                  KIND_RESULT, 16'h0000, PST_OPEN, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_RESP, '0, 32'd0, 16'd40000, 16'hFFFF, 0, 1),
                                  KIND_RESULT, 16'hFFFF, PST_CLOSED, 16'd0)};
        rows = {rows, cmd_row(CMD_RESP, '0, 32'd0, 16'd40000, 16'h0000, 1, 0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'd80, '0, '0, '0, 0, 0),
                                  KIND_SEND, 16'd80, PST_NONE, 16'd0)};
        rows = {rows, cmd_row(CMD_RESP, '0, 32'hFFFF_FFFF, 16'd40000, 16'd80, 1, 0)};
        rows = {rows, cmd_row(CMD_RESP, '0, 32'd0, 16'hFFFF, 16'd80, 1, 0)};
        rows = {rows, cmd_row(CMD_RESP, '0, 32'd0, 16'd40000, 16'd80, 0, 0)};
        rows = {rows, cmd_row(CMD_TICK, '1, '1, '1, '1, 1, 1)};
        rows = {rows, with_result(cmd_row(CMD_FLUSH, '0, '0, '0, '0, 0, 0),
                                  KIND_RESULT, 16'd80, PST_UNKNOWN, 16'd0)};
        rows = {rows, cmd_row(CMD_FLUSH, '1, '1, '1, '1, 1, 1)};
        rows = {rows, cmd_row(CMD_TICK, '0, '0, '0, '0, 0, 0)};
        // zero timeout, no retries, two slots: full table beats duplicate
        rows = {rows, cfg_row(CFG_TIMEOUT_TICKS, 32'd0)};
        rows = {rows, cfg_row(CFG_RETRY_COUNT, 32'd0)};
        rows = {rows, cfg_row(CFG_MAX_IN_FLIGHT, 32'd2)};
        rows = {rows, cfg_row(CFG_LOCAL_PORT, 32'hFFFF)};
        rows = {rows, cfg_row(CFG_TARGET_ADDR, 32'hFFFF_FFFF)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'd7, '0, '0, '0, 0, 0),
                                  KIND_SEND, 16'd7, PST_NONE, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'd8, '0, '0, '0, 0, 0),
                                  KIND_SEND, 16'd8, PST_NONE, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'd9, '0, '0, '0, 0, 0),
                                  KIND_BUSY, 16'd9, PST_NONE, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'd7, '0, '0, '0, 0, 0),
                                  KIND_BUSY, 16'd7, PST_NONE, 16'd0)};
        rows = {rows, cmd_row(CMD_TICK, '0, '0, '0, '0, 0, 0)};
        // slot limit of zero acts as one; longest timeout, most retries
        rows = {rows, cfg_row(CFG_MAX_IN_FLIGHT, 32'd0)};
        rows = {rows, cfg_row(CFG_TIMEOUT_TICKS, 32'hFFFF)};
        rows = {rows, cfg_row(CFG_RETRY_COUNT, 32'd15)};
        rows = {rows, cfg_row(CFG_LOCAL_PORT, 32'd0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'd1, '0, '0, '0, 0, 0),
                                  KIND_SEND, 16'd1, PST_NONE, 16'd0)};
        rows = {rows, with_result(cmd_row(CMD_ISSUE, 16'd2, '0, '0, '0, 0, 0),
                                  KIND_BUSY, 16'd2, PST_NONE, 16'd0)};
        rows = {rows, cmd_row(CMD_TICK, '0, '0, '0, '0, 0, 0)};
        rows = {rows, cmd_row(CMD_RESP, '0, 32'hFFFF_FFFF, 16'd0, 16'd1, 0, 1)};
        // slot limit above the table size saturates; resend on expiry
        rows = {rows, cfg_row(CFG_MAX_IN_FLIGHT, 32'd31)};
        rows = {rows, cfg_row(CFG_TIMEOUT_TICKS, 32'd2)};
        rows = {rows, cfg_row(CFG_RETRY_COUNT, 32'd2)};
        rows = {rows, cmd_row(CMD_ISSUE, 16'd3, '0, '0, '0, 0, 0)};
        rows = {rows, cmd_row(CMD_ISSUE, 16'd4, '0, '0, '0, 0, 0)};
        rows = {rows, cmd_row(CMD_TICK, '0, '0, '0, '0, 0, 0)};
        rows = {rows, cmd_row(CMD_TICK, '0, '0, '0, '0, 0, 0)};
        rows = {rows, cmd_row(CMD_FLUSH, '0, '0, '0, '0, 0, 0)};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_started = 1'b1;

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                if (r == 0 || !rows[r-1].is_cfg) wait_drained();
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                offer(rows[r].cmd, rows[r].has_res, rows[r].res, n);
            end
        end
        items_directed = items_in;

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            write_reg(CFG_LOCAL_PORT, (phase == 0) ? 32'd0 :
                                      (phase == 1) ? 32'hFFFF : $urandom_range(0, 65535));
            write_reg(CFG_TARGET_ADDR, (phase == 0) ? 32'd0 :
                                       (phase == 1) ? 32'hFFFF_FFFF : $urandom);
            write_reg(CFG_TIMEOUT_TICKS, (phase == 2) ? 32'd1 :
                                         (phase == 4) ? 32'hFFFF : $urandom_range(2, 10));
            write_reg(CFG_RETRY_COUNT, (phase == 1) ? 32'd15 :
                                       (phase == 2) ? 32'd0 : $urandom_range(0, 3));
            write_reg(CFG_MAX_IN_FLIGHT, 32'(max_list[phase]));
            for (int k = 0; k < PORT_POOL; k++) port_pool[k] = 16'($urandom);
            // long result back-pressure while commands keep coming
            if (phase == 3) pressure_req = 1'b1;
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it = random_probe();
                offer(it, 1'b0, '0, n);
                counted++;
            end
        end

        wait_drained();
        $display("Run covered %0d commands (%0d directed) under %0d register writes;",
                 items_in, items_directed, settings_used);
        $display("checked %0d send requests, %0d port results, %0d busy rejects, %0d errors",
                 kind_cnt[0], kind_cnt[1], kind_cnt[2], err_cnt);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/syn_pt_pkg.sv
sv/syn_pt_in_if.sv
sv/syn_pt_out_if.sv
sv/syn_pt_mem.sv
sv/syn_pt_out.sv
sv/syn_probe_tracker.sv
tb/sv/tb_top.sv
